FILE: rtl/hkl_auk_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hkl_auk_pkg
// types, constants and arithmetic helpers for the asymmetric unit key unit
// ---------------------------------------------------------------------------
package hkl_auk_pkg;

    // matrix layout: 9 signed 3-bit entries per operation, column-major
    localparam int ENTRIES     = 9;
    localparam int ENTRY_W     = 3;
    localparam int ROW_W       = ENTRIES * ENTRY_W;

    localparam int IDX_W       = 11;
    localparam int KEY_W       = 14;
    localparam int SUM_W       = 16;
    localparam int CNT_REG_W   = 7;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * KEY_W;

    // tuser selector
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic signed [IDX_W-1:0]   t_idx;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [KEY_W-1:0]   t_key;
    typedef logic [ROW_W-1:0]          t_row;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_QUERY,
        ST_DRAIN,
        ST_DONE
    } t_state;

    localparam t_key KEY_MAX = t_key'(8191);
    localparam t_key KEY_MIN = t_key'(-8192);

    // one row of the transform: e0*x + e1*y + e2*z at full precision
    function automatic t_sum hkl_dot(input t_entry e0, input t_entry e1,
                                     input t_entry e2, input t_idx x,
                                     input t_idx y, input t_idx z);
        t_sum p0;
        t_sum p1;
        t_sum p2;
        p0 = t_sum'(e0) * t_sum'(x);
        p1 = t_sum'(e1) * t_sum'(y);
        p2 = t_sum'(e2) * t_sum'(z);
        return p0 + p1 + p2;
    endfunction

    // strictly larger, comparing c, then b, then a
    function automatic logic hkl_greater(input t_sum a, input t_sum b, input t_sum c,
                                         input t_sum ka, input t_sum kb, input t_sum kc);
        logic res;
        if (c != kc) begin
            res = (c > kc);
        end else if (b != kb) begin
            res = (b > kb);
        end else begin
            res = (a > ka);
        end
        return res;
    endfunction

    function automatic t_key hkl_sat(input t_sum v);
        t_key res;
        if (v > t_sum'(KEY_MAX)) begin
            res = KEY_MAX;
        end else if (v < t_sum'(KEY_MIN)) begin
            res = KEY_MIN;
        end else begin
            res = v[KEY_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/hkl_auk_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hkl_auk_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module hkl_auk_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 64
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic                                        i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/hkl_asymmetric_unit_key_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hkl_asymmetric_unit_key_unit
// reduces miller indices to a unique key over a loadable table of symmetry ops
// ---------------------------------------------------------------------------
//
// channel   dir  fields
// --------  ---  -----------------------------------------------------------
// s_axis    in   tuser mode, tdata op/entry/value/h/k/l, tlast last_ref
// m_axis    out  tdata key_h/key_k/key_l, tlast batch_end
// cfg       in   i_cfg_we / i_cfg_wdata : op_count
//
// a query steps through n = min(op_count, MAX_OPS) operation rows, or goes straight
// to the result when n is zero; the table ram gives one operation row per cycle and
// both signs are tried on that row at once
// a load reads the row, then writes it back with one entry changed
// the input takes a transfer only when the sequencer is idle; the result sits in
// an output register, so the next item is taken while the result still waits,
// but a query that finishes before that result leaves holds until it does
// reset clears the sequencer, the output valid and op_count (back to 1); the
// table itself is not cleared and must be loaded before use
//
module hkl_asymmetric_unit_key_unit #(
    parameter int MAX_OPS = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // slave stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // op_index[5:0], entry_index[9:6], entry_value[12:10], h[23:13],
    // k[34:24], l[45:35], zero pad
    input  wire logic [hkl_auk_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // mode
    input  wire logic                                  s_axis_tuser,
    input  wire logic                                  s_axis_tlast,
    // master stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // key_h[13:0], key_k[27:14], key_l[41:28], zero pad
    output logic      [hkl_auk_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                       m_axis_tlast,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic [hkl_auk_pkg::CNT_REG_W-1:0]     i_cfg_wdata
);

    import hkl_auk_pkg::*;

    // address width of the table and width wide enough to compare counts
    localparam int AW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int NW = ($clog2(MAX_OPS + 1) > CNT_REG_W) ? $clog2(MAX_OPS + 1)
                                                         : CNT_REG_W;

    // input field unpacking
    logic [5:0]  w_in_op;
    logic [3:0]  w_in_ent;
    t_entry      w_in_val;
    t_idx        w_in_h;
    t_idx        w_in_k;
    t_idx        w_in_l;

    assign w_in_op  = s_axis_tdata[5:0];
    assign w_in_ent = s_axis_tdata[9:6];
    assign w_in_val = s_axis_tdata[12:10];
    assign w_in_h   = s_axis_tdata[23:13];
    assign w_in_k   = s_axis_tdata[34:24];
    assign w_in_l   = s_axis_tdata[45:35];

    // control registers
    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_REG_W-1:0]   r_op_count;
    logic                   r_rd_vld;
    logic                   r_sum_vld;
    logic                   r_out_vld;

    // payload registers
    logic [AW-1:0]          r_op;
    logic [AW-1:0]          r_last_op;
    logic [AW-1:0]          r_wop;
    logic [3:0]             r_ent;
    t_entry                 r_val;
    t_idx                   r_h;
    t_idx                   r_k;
    t_idx                   r_l;
    logic                   r_last;
    t_sum                   r_sa;
    t_sum                   r_sb;
    t_sum                   r_sc;
    t_sum                   r_kh;
    t_sum                   r_kk;
    t_sum                   r_kl;
    t_key                   r_out_h;
    t_key                   r_out_k;
    t_key                   r_out_l;
    logic                   r_out_last;

    // ram side
    logic                   w_ram_we;
    logic                   w_ram_re;
    logic [AW-1:0]          w_ram_raddr;
    t_row                   w_ram_rdata;
    t_row                   w_wr_row;

    logic                   w_in_xfer;
    logic                   w_load_ok;
    logic [NW-1:0]          w_n_ops;
    logic                   w_out_load;

    assign w_in_xfer = s_axis_tvalid & s_axis_tready;

    // operations in use, clamped to the table depth
    assign w_n_ops = (NW'(r_op_count) > NW'(MAX_OPS)) ? NW'(MAX_OPS) : NW'(r_op_count);

    // loads outside the table are dropped
    assign w_load_ok = (NW'(w_in_op) < NW'(MAX_OPS)) && (w_in_ent < 4'(ENTRIES));

    // row merge for the entry being loaded
    always_comb begin
        w_wr_row = w_ram_rdata;
        for (int p = 0; p < ENTRIES; p++) begin
            if (r_ent == 4'(p)) begin
                w_wr_row[p*ENTRY_W +: ENTRY_W] = r_val;
            end
        end
    end

    hkl_auk_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_OPS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wop),
        .i_wdata (w_wr_row),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // sequencer: next state and strobes
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_ram_re      = 1'b0;
        w_ram_we      = 1'b0;
        w_ram_raddr   = r_op;
        w_out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == MODE_LOAD) begin
                        if (w_load_ok) begin
                            w_ram_re    = 1'b1;
                            w_ram_raddr = AW'(w_in_op);
                            n_state     = ST_LOAD;
                        end
                    end else if (w_n_ops == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_QUERY;
                    end
                end
            end
            ST_LOAD: begin
                // read data of the row arrives now, write it back merged
                w_ram_we = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_QUERY: begin
                w_ram_re = 1'b1;
                if (r_op == r_last_op) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !r_sum_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // compare stage: pick the larger of +/- candidate, then test against the key
    t_sum w_na;
    t_sum w_nb;
    t_sum w_nc;
    t_sum w_ca;
    t_sum w_cb;
    t_sum w_cc;
    logic w_pos;
    logic w_upd;

    always_comb begin
        w_na  = -r_sa;
        w_nb  = -r_sb;
        w_nc  = -r_sc;
        w_pos = hkl_greater(r_sa, r_sb, r_sc, w_na, w_nb, w_nc);
        w_ca  = w_pos ? r_sa : w_na;
        w_cb  = w_pos ? r_sb : w_nb;
        w_cc  = w_pos ? r_sc : w_nc;
        w_upd = hkl_greater(w_ca, w_cb, w_cc, r_kh, r_kk, r_kl);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_op_count <= CNT_REG_W'(1);
            r_rd_vld   <= 1'b0;
            r_sum_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= (r_state == ST_QUERY);
            r_sum_vld <= r_rd_vld;
            if (i_cfg_we) begin
                r_op_count <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_wop     <= AW'(w_in_op);
            r_ent     <= w_in_ent;
            r_val     <= w_in_val;
            r_h       <= w_in_h;
            r_k       <= w_in_k;
            r_l       <= w_in_l;
            r_last    <= s_axis_tlast;
            r_op      <= '0;
            r_last_op <= AW'(w_n_ops - NW'(1));
            // the key starts as the reflection itself
            r_kh      <= t_sum'(w_in_h);
            r_kk      <= t_sum'(w_in_k);
            r_kl      <= t_sum'(w_in_l);
        end else begin
            if (r_state == ST_QUERY) begin
                r_op <= r_op + AW'(1);
            end
            if (r_sum_vld && w_upd) begin
                r_kh <= w_ca;
                r_kk <= w_cb;
                r_kl <= w_cc;
            end
        end
        // transform stage on the row just read
        if (r_rd_vld) begin
            r_sa <= hkl_dot(w_ram_rdata[0*ENTRY_W +: ENTRY_W],
                            w_ram_rdata[3*ENTRY_W +: ENTRY_W],
                            w_ram_rdata[6*ENTRY_W +: ENTRY_W], r_h, r_k, r_l);
            r_sb <= hkl_dot(w_ram_rdata[1*ENTRY_W +: ENTRY_W],
                            w_ram_rdata[4*ENTRY_W +: ENTRY_W],
                            w_ram_rdata[7*ENTRY_W +: ENTRY_W], r_h, r_k, r_l);
            r_sc <= hkl_dot(w_ram_rdata[2*ENTRY_W +: ENTRY_W],
                            w_ram_rdata[5*ENTRY_W +: ENTRY_W],
                            w_ram_rdata[8*ENTRY_W +: ENTRY_W], r_h, r_k, r_l);
        end
        if (w_out_load) begin
            r_out_h    <= hkl_sat(r_kh);
            r_out_k    <= hkl_sat(r_kk);
            r_out_l    <= hkl_sat(r_kl);
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_out_l, r_out_k, r_out_h};
    assign m_axis_tlast  = r_out_last;

    // checks on the sequencer and the table pipeline
    a_sum_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_vld |-> (r_state == ST_QUERY || r_state == ST_DRAIN))
        else $error("compare stage busy outside a query");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> $past(w_ram_re))
        else $error("table write without a row read before it");

    a_op_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QUERY) |-> (r_op <= r_last_op))
        else $error("operation counter ran past the last operation");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_rd_vld && !r_sum_vld))
        else $error("result taken before the pipeline drained");

endmodule
`default_nettype wire
